// ----- hdl/tslc_pkg.sv -----
`default_nettype none

package tslc_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 64;
  localparam int STAMP_BITS = 32;
  localparam int IDX_BITS   = $clog2(ENTRIES);

  localparam int KEY_W  = 64;
  localparam int SIZE_W = 16;
  localparam int SLOT_W = 4;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_TOUCH,
    WR_FILL,
    WR_DROP
  } wr_op_t;

  // search record that walks down the row of cells, one cell a cycle
  typedef struct packed {
    logic                  live;
    logic                  match;
    logic [IDX_BITS-1:0]   match_idx;
    logic [SIZE_W-1:0]     match_w;
    logic [SIZE_W-1:0]     match_h;
    logic                  free;
    logic [IDX_BITS-1:0]   free_idx;
    logic [STAMP_BITS-1:0] best_stamp;
    logic [IDX_BITS-1:0]   best_idx;
  } scan_rec_t;

  // update broadcast to all cells once the record leaves the last cell
  typedef struct packed {
    wr_op_t                op;
    logic [IDX_BITS-1:0]   idx;
    logic [KEY_BITS-1:0]   key;
    logic [STAMP_BITS-1:0] stamp;
    logic [SIZE_W-1:0]     w;
    logic [SIZE_W-1:0]     h;
  } wr_cmd_t;

  typedef struct packed {
    logic              hit;
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } res_t;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_BITS-1:0] idx);
    logic [IDX_BITS+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/tslc_ifs.sv -----
`default_nettype none

interface tslc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [tslc_pkg::KEY_W-1:0]  key;
  logic                        load_ok;
  logic [tslc_pkg::SIZE_W-1:0] img_width;
  logic [tslc_pkg::SIZE_W-1:0] img_height;

  modport source (output valid, cmd, key, load_ok, img_width, img_height, input ready);
  modport sink   (input valid, cmd, key, load_ok, img_width, img_height, output ready);
endinterface

interface tslc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic                        ok;
  logic [tslc_pkg::SLOT_W-1:0] slot;
  logic [tslc_pkg::SIZE_W-1:0] out_width;
  logic [tslc_pkg::SIZE_W-1:0] out_height;

  modport source (output valid, hit, ok, slot, out_width, out_height, input ready);
  modport sink   (input valid, hit, ok, slot, out_width, out_height, output ready);
endinterface

`default_nettype wire

// ----- hdl/tslc_cell.sv -----
`default_nettype none

module tslc_cell (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [tslc_pkg::IDX_BITS-1:0]     cell_idx,
  input  wire logic [tslc_pkg::KEY_BITS-1:0]     req_key,
  input  wire tslc_pkg::scan_rec_t               rec_i,
  input  wire tslc_pkg::wr_cmd_t                 wr,
  output tslc_pkg::scan_rec_t                    rec_o
);

  logic                            valid_r;
  logic [tslc_pkg::KEY_BITS-1:0]   key_r;
  logic [tslc_pkg::STAMP_BITS-1:0] stamp_r;
  logic [tslc_pkg::SIZE_W-1:0]     w_r;
  logic [tslc_pkg::SIZE_W-1:0]     h_r;
  tslc_pkg::scan_rec_t             rec_r;
  tslc_pkg::scan_rec_t             rec_nxt;

  always_comb begin
    rec_nxt = rec_i;
    if (rec_i.live) begin
      // first valid match wins
      if (valid_r && key_r == req_key && !rec_i.match) begin
        rec_nxt.match     = 1'b1;
        rec_nxt.match_idx = cell_idx;
        rec_nxt.match_w   = w_r;
        rec_nxt.match_h   = h_r;
      end
      if (!valid_r && !rec_i.free) begin
        rec_nxt.free     = 1'b1;
        rec_nxt.free_idx = cell_idx;
      end
      // strict compare keeps the lowest index on a tie
      if (cell_idx == '0 || stamp_r < rec_i.best_stamp) begin
        rec_nxt.best_stamp = stamp_r;
        rec_nxt.best_idx   = cell_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      stamp_r <= '0;
      rec_r   <= '0;
    end else begin
      rec_r <= rec_nxt;
      if (wr.idx == cell_idx) begin
        case (wr.op)
          tslc_pkg::WR_TOUCH: stamp_r <= wr.stamp;
          tslc_pkg::WR_FILL: begin
            valid_r <= 1'b1;
            stamp_r <= wr.stamp;
            key_r   <= wr.key;
            w_r     <= wr.w;
            h_r     <= wr.h;
          end
          tslc_pkg::WR_DROP: valid_r <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  assign rec_o = rec_r;

endmodule

`default_nettype wire

// ----- hdl/texture_slot_lru_cache.sv -----
// channel   dir   beat contents
// in_ch     in    cmd, key, load_ok, img_width, img_height
// out_ch    out   hit, ok, slot, out_width, out_height
//
// a frame tick steps the frame counter, then S_DONE loads the output register
// a lookup passes its search record through the head register, then one cell
// of the entry row per cycle; S_SCAN then decides, updates the entry and
// registers the result, and S_DONE loads the output register
// one item is in work at a time; the next is taken while a result waits
// rst_n clears all entries' valid bits, stamps and the frame counter at once
// a stalled result holds in the output register; a following finished result
// then waits with in_ch.ready low until the output register frees up
`default_nettype none

module texture_slot_lru_cache (
  input wire logic   clk,
  input wire logic   rst_n,
  tslc_in_if.sink    in_ch,
  tslc_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                          state_r;
  logic [tslc_pkg::STAMP_BITS-1:0] frame_r;
  logic [tslc_pkg::KEY_BITS-1:0]   key_r;
  logic                            load_ok_r;
  logic [tslc_pkg::SIZE_W-1:0]     w_r;
  logic [tslc_pkg::SIZE_W-1:0]     h_r;
  tslc_pkg::scan_rec_t             head_r;
  tslc_pkg::scan_rec_t             head_nxt;
  tslc_pkg::res_t                  res_r;
  tslc_pkg::res_t                  res_nxt;
  tslc_pkg::res_t                  out_r;
  logic                            out_valid_r;
  tslc_pkg::wr_cmd_t               wr;
  tslc_pkg::scan_rec_t             rec [tslc_pkg::ENTRIES+1];
  tslc_pkg::scan_rec_t             tail;
  logic                            in_fire;
  logic [tslc_pkg::IDX_BITS-1:0]   chosen;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign rec[0]      = head_r;
  assign tail        = rec[tslc_pkg::ENTRIES];

  always_comb begin
    head_nxt      = '0;
    head_nxt.live = in_fire && (in_ch.cmd == tslc_pkg::CMD_LOOKUP);
  end

  generate
    for (genvar i = 0; i < tslc_pkg::ENTRIES; i++) begin : g_cell
      tslc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (tslc_pkg::IDX_BITS'(i)),
        .req_key  (key_r),
        .rec_i    (rec[i]),
        .wr       (wr),
        .rec_o    (rec[i+1])
      );
    end
  endgenerate

  // decision once the record leaves the last cell
  always_comb begin
    chosen   = tail.free ? tail.free_idx : tail.best_idx;
    wr       = '0;
    wr.op    = tslc_pkg::WR_NONE;
    wr.key   = key_r;
    wr.stamp = frame_r;
    wr.w     = w_r;
    wr.h     = h_r;
    res_nxt  = '0;
    if (tail.match) begin
      wr.idx       = tail.match_idx;
      res_nxt.hit  = 1'b1;
      res_nxt.ok   = 1'b1;
      res_nxt.slot = tslc_pkg::to_slot(tail.match_idx);
      res_nxt.w    = tail.match_w;
      res_nxt.h    = tail.match_h;
    end else begin
      wr.idx       = chosen;
      res_nxt.slot = tslc_pkg::to_slot(chosen);
      if (load_ok_r) begin
        res_nxt.ok = 1'b1;
        res_nxt.w  = w_r;
        res_nxt.h  = h_r;
      end
    end
    if (state_r == S_SCAN && tail.live) begin
      if (tail.match)
        wr.op = tslc_pkg::WR_TOUCH;
      else if (load_ok_r)
        wr.op = tslc_pkg::WR_FILL;
      else if (!tail.free)
        wr.op = tslc_pkg::WR_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frame_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      // a new beat may follow straight on from the one being taken
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready))
        out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready)
        out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_ch.cmd == tslc_pkg::CMD_TICK) begin
              frame_r <= frame_r + tslc_pkg::STAMP_BITS'(1);
              res_r   <= '{hit: 1'b0, ok: 1'b1, slot: '0, w: '0, h: '0};
              state_r <= S_DONE;
            end else begin
              key_r     <= in_ch.key[tslc_pkg::KEY_BITS-1:0];
              load_ok_r <= in_ch.load_ok;
              w_r       <= in_ch.img_width;
              h_r       <= in_ch.img_height;
              state_r   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (tail.live) begin
            res_r   <= res_nxt;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_r.hit;
  assign out_ch.ok         = out_r.ok;
  assign out_ch.slot       = out_r.slot;
  assign out_ch.out_width  = out_r.w;
  assign out_ch.out_height = out_r.h;

endmodule

`default_nettype wire

// ----- hdl/tslc_chk.sv -----
`default_nettype none

module tslc_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        out_hit,
  input wire logic                        out_ok,
  input wire logic [tslc_pkg::SLOT_W-1:0] out_slot
);

  // a waiting result beat keeps its slot
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot))
    else $error("result beat dropped or changed while stalled");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_ok)
    else $error("hit reported without ok");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while the first is in work");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat shown after reset");

endmodule

bind texture_slot_lru_cache tslc_chk u_tslc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hit   (out_ch.hit),
  .out_ok    (out_ch.ok),
  .out_slot  (out_ch.slot)
);

`default_nettype wire
